FILE: sv/srr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srr_pkg: shared types and constants of the scan ray resampler
// Field widths, register indexes, reset values, request types and the controller/datapath interface.
// ----------------------------------------------------------------------------
package srr_pkg;

  localparam int RANGE_W  = 16;
  localparam int RETRO_W  = 16;
  localparam int RAYIDX_W = 10;
  localparam int BEAM_W   = 12;
  localparam int RCOUNT_W = 11;
  localparam int BCOUNT_W = 13;
  localparam int FRAC_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RAY_COUNT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BEAM_COUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTENSITY = 3'd4;

  // reset values of the configuration registers
  localparam logic [RCOUNT_W-1:0] RST_RAY_COUNT     = 11'd720;
  localparam logic [BCOUNT_W-1:0] RST_BEAM_COUNT    = 13'd720;
  localparam logic [RANGE_W-1:0]  RST_MIN_RANGE     = 16'd0;
  localparam logic [RANGE_W-1:0]  RST_MAX_RANGE     = 16'hFFFF;
  localparam logic [RETRO_W-1:0]  RST_MIN_INTENSITY = 16'd101;

  // request types
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic load_wr;     // write one ray into the store
    logic query_take;  // latch query index and range check
    logic pos_calc;    // pos multiply, load divider
    logic div_step;    // one divider iteration
    logic mem_rd;      // read rays a and b
    logic interp;      // clamp, weight multiply, intensity average
    logic out_load;    // final add/clamp into output register
  } srr_cmd_t;

  typedef struct packed {
    logic idx_err;
    logic div_last;
    logic out_free;
  } srr_sts_t;

endpackage
`default_nettype wire

FILE: sv/srr_ray_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srr_ray_store: ray range and retro intensity memory
// One write port, two registered read ports.
// ----------------------------------------------------------------------------
module srr_ray_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [AW-1:0]                wr_addr,
  input  wire logic [srr_pkg::RANGE_W-1:0]  wr_range,
  input  wire logic [srr_pkg::RETRO_W-1:0]  wr_retro,
  input  wire logic                         rd_en,
  input  wire logic [AW-1:0]                rd_addr_a,
  input  wire logic [AW-1:0]                rd_addr_b,
  output logic      [srr_pkg::RANGE_W-1:0]  rd_range_a,
  output logic      [srr_pkg::RANGE_W-1:0]  rd_range_b,
  output logic      [srr_pkg::RETRO_W-1:0]  rd_retro_a,
  output logic      [srr_pkg::RETRO_W-1:0]  rd_retro_b
);
  import srr_pkg::*;

  logic [RANGE_W-1:0] range_mem [DEPTH];
  logic [RETRO_W-1:0] retro_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      range_mem[wr_addr] <= wr_range;
      retro_mem[wr_addr] <= wr_retro;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_range_a <= range_mem[rd_addr_a];
      rd_range_b <= range_mem[rd_addr_b];
      rd_retro_a <= retro_mem[rd_addr_a];
      rd_retro_b <= retro_mem[rd_addr_b];
    end
  end

endmodule
`default_nettype wire

FILE: sv/srr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srr_ctrl: sequencer of the scan ray resampler
// Accepts items, walks a query through multiply, divide, read and interpolate.
// ----------------------------------------------------------------------------
module srr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_req_type,
  output logic                   in_ready,
  output srr_pkg::srr_cmd_t      cmd,
  input  wire srr_pkg::srr_sts_t sts
);
  import srr_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_DIV  = 6'b000100,
    S_RD   = 6'b001000,
    S_MAC  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req_type == REQ_LOAD) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.query_take = 1'b1;
            state_nxt      = S_MUL;
          end
        end
      end
      S_MUL: begin
        // out-of-range queries skip straight to the output stage
        if (sts.idx_err) begin
          state_nxt = S_FIN;
        end else begin
          cmd.pos_calc = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_MAC;
      end
      S_MAC: begin
        cmd.interp = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/srr_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srr_datapath: configuration, divider, ray store and interpolation
// Radix-4 restoring divider gives ray index and 16-bit fraction together.
// ----------------------------------------------------------------------------
module srr_datapath #(
  parameter int MAX_RAYS = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire srr_pkg::srr_cmd_t               cmd,
  output srr_pkg::srr_sts_t                    sts,
  input  wire logic [srr_pkg::RAYIDX_W-1:0]    in_ray_index,
  input  wire logic [srr_pkg::RANGE_W-1:0]     in_ray_range,
  input  wire logic [srr_pkg::RETRO_W-1:0]     in_ray_retro,
  input  wire logic [srr_pkg::BEAM_W-1:0]      in_beam_index,
  input  wire logic                            cfg_valid,
  input  wire logic [srr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [srr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [srr_pkg::RANGE_W-1:0]     out_beam_range,
  output logic      [srr_pkg::RETRO_W-1:0]     out_beam_intensity,
  output logic      [srr_pkg::BEAM_W-1:0]      out_beam_number,
  output logic                                 out_index_error
);
  import srr_pkg::*;

  localparam int RA_W   = $clog2(MAX_RAYS);
  localparam int POS_W  = BEAM_W + RA_W;
  localparam int DIV_W  = ((POS_W + FRAC_W + 1) / 2) * 2;
  localparam int QI_W   = DIV_W - FRAC_W;
  localparam int STEPS  = DIV_W / 2;
  localparam int CNT_W  = $clog2(STEPS + 1);
  localparam int DEN_W  = BCOUNT_W;
  localparam int SLOT_W = RA_W + RAYIDX_W;
  localparam int PROD_W = 2 * (RANGE_W + 1);

  // configuration registers
  logic [RCOUNT_W-1:0] ray_count_r;
  logic [BCOUNT_W-1:0] beam_count_r;
  logic [RANGE_W-1:0]  min_range_r;
  logic [RANGE_W-1:0]  max_range_r;
  logic [RETRO_W-1:0]  min_intensity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_count_r     <= RST_RAY_COUNT;
      beam_count_r    <= RST_BEAM_COUNT;
      min_range_r     <= RST_MIN_RANGE;
      max_range_r     <= RST_MAX_RANGE;
      min_intensity_r <= RST_MIN_INTENSITY;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RAY_COUNT:     ray_count_r     <= cfg_data[RCOUNT_W-1:0];
        CFG_BEAM_COUNT:    beam_count_r    <= cfg_data[BCOUNT_W-1:0];
        CFG_MIN_RANGE:     min_range_r     <= cfg_data;
        CFG_MAX_RANGE:     max_range_r     <= cfg_data;
        CFG_MIN_INTENSITY: min_intensity_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // effective last ray and divisor
  logic [RA_W-1:0]  rays_m1;
  logic [DEN_W-1:0] den;

  always_comb begin
    if (ray_count_r == '0) begin
      rays_m1 = '0;
    end else if (32'(ray_count_r) > MAX_RAYS) begin
      rays_m1 = RA_W'(MAX_RAYS - 1);
    end else begin
      rays_m1 = RA_W'(ray_count_r - 1'b1);
    end
    den = (beam_count_r < DEN_W'(2)) ? DEN_W'(1) : beam_count_r - 1'b1;
  end

  // query latch
  logic [BEAM_W-1:0] idx_r;
  logic              err_r;

  always_ff @(posedge clk) begin
    if (cmd.query_take) begin
      idx_r <= in_beam_index;
      err_r <= ({1'b0, in_beam_index} >= beam_count_r);
    end
  end

  // divider: q_r holds {pos, 16'b0} and shifts the quotient in
  logic [DIV_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [POS_W-1:0] pos;

  assign pos = POS_W'(idx_r) * POS_W'(rays_m1);

  always_comb begin
    logic [DEN_W:0]   trial;
    logic [DEN_W-1:0] rem_v;
    logic [DIV_W-1:0] q_v;
    rem_v = rem_r;
    q_v   = q_r;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_v, q_v[DIV_W-1]};
      q_v   = {q_v[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        trial  = trial - {1'b0, den};
        q_v[0] = 1'b1;
      end
      rem_v = trial[DEN_W-1:0];
    end
    q_nxt   = q_v;
    rem_nxt = rem_v;
  end

  always_ff @(posedge clk) begin
    if (cmd.pos_calc) begin
      q_r   <= DIV_W'({pos, {FRAC_W{1'b0}}});
      rem_r <= '0;
    end else if (cmd.div_step) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.pos_calc) begin
      cnt_r <= CNT_W'(STEPS);
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // ray addresses, a clamped to the last ray, b one past a but no further than the last ray
  logic [QI_W-1:0]   quo;
  logic [FRAC_W-1:0] frac;
  logic [RA_W-1:0]   addr_a, addr_b;

  assign quo  = q_r[DIV_W-1:FRAC_W];
  assign frac = q_r[FRAC_W-1:0];

  always_comb begin
    if (quo > QI_W'(rays_m1)) begin
      addr_a = rays_m1;
    end else begin
      addr_a = quo[RA_W-1:0];
    end
    addr_b = (addr_a >= rays_m1) ? rays_m1 : addr_a + 1'b1;
  end

  // store write port
  logic [SLOT_W-1:0] slot_w;
  logic              slot_ok;

  assign slot_w  = SLOT_W'(in_ray_index);
  assign slot_ok = (32'(in_ray_index) < MAX_RAYS);

  logic [RANGE_W-1:0] rng_a, rng_b;
  logic [RETRO_W-1:0] ret_a, ret_b;

  srr_ray_store #(
    .DEPTH (MAX_RAYS),
    .AW    (RA_W)
  ) u_store (
    .clk        (clk),
    .wr_en      (cmd.load_wr && slot_ok),
    .wr_addr    (slot_w[RA_W-1:0]),
    .wr_range   (in_ray_range),
    .wr_retro   (in_ray_retro),
    .rd_en      (cmd.mem_rd),
    .rd_addr_a  (addr_a),
    .rd_addr_b  (addr_b),
    .rd_range_a (rng_a),
    .rd_range_b (rng_b),
    .rd_retro_a (ret_a),
    .rd_retro_b (ret_b)
  );

  // interpolation: r = ra + ((rb - ra) * f) >>> 16
  logic [RANGE_W-1:0]        span, ra, rb;
  logic signed [RANGE_W:0]   diff;
  logic [RETRO_W:0]          ret_sum;
  logic [RETRO_W-1:0]        inten;
  logic signed [PROD_W-1:0]  prod_r;
  logic [RANGE_W-1:0]        ra_r;
  logic [RETRO_W-1:0]        inten_r;

  always_comb begin
    span    = (max_range_r > min_range_r) ? max_range_r - min_range_r : '0;
    ra      = (rng_a > span) ? span : rng_a;
    rb      = (rng_b > span) ? span : rng_b;
    diff    = $signed({1'b0, rb}) - $signed({1'b0, ra});
    ret_sum = (RETRO_W+1)'(ret_a) + (RETRO_W+1)'(ret_b);
    inten   = ret_sum[RETRO_W:1];
    if (inten < min_intensity_r) begin
      inten = min_intensity_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.interp) begin
      prod_r  <= PROD_W'(diff * $signed({1'b0, frac}));
      ra_r    <= ra;
      inten_r <= inten;
    end
  end

  // final offset and clamp
  logic signed [PROD_W-1:0]  shifted;
  logic signed [RANGE_W+1:0] r_v;
  logic [RANGE_W:0]          sum_v;
  logic [RANGE_W-1:0]        beam_range;

  always_comb begin
    shifted = prod_r >>> FRAC_W;
    r_v     = $signed({2'b00, ra_r}) + shifted[RANGE_W+1:0];
    sum_v   = (RANGE_W+1)'(r_v[RANGE_W-1:0]) + (RANGE_W+1)'(min_range_r);
    if (sum_v > (RANGE_W+1)'(max_range_r)) begin
      beam_range = max_range_r;
    end else begin
      beam_range = sum_v[RANGE_W-1:0];
    end
  end

  // output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_beam_number <= idx_r;
      out_index_error <= err_r;
      if (err_r) begin
        out_beam_range     <= '0;
        out_beam_intensity <= '0;
      end else begin
        out_beam_range     <= beam_range;
        out_beam_intensity <= inten_r;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.idx_err  = err_r;
  assign sts.div_last = (cnt_r == CNT_W'(1));
  assign sts.out_free = !out_valid_r || out_ready;

endmodule
`default_nettype wire

FILE: sv/scan_ray_resampler_unit.sv
`default_nettype none
// A query walks the multiply, divide, read, interpolate and output states; the divider
// is 2 * STEPS bits wide, STEPS being (12 + log2(MAX_RAYS) + 17) / 2, two bits per step.
// No new item is accepted until a query's result has entered the output register.
// Load transactions are taken one per cycle while idle; index errors skip the divider.
// Synchronous active-low reset clears the sequencer, output valid and
// configuration registers; the ray store holds undefined data until written.
// ----------------------------------------------------------------------------
// scan_ray_resampler_unit: linear interpolation scan resampler
// Stores one scan and resamples it to a configured number of beams.
// ----------------------------------------------------------------------------
module scan_ray_resampler_unit #(
  parameter int MAX_RAYS = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_req_type,
  input  wire logic [srr_pkg::RAYIDX_W-1:0]    in_ray_index,
  input  wire logic [srr_pkg::RANGE_W-1:0]     in_ray_range,
  input  wire logic [srr_pkg::RETRO_W-1:0]     in_ray_retro,
  input  wire logic [srr_pkg::BEAM_W-1:0]      in_beam_index,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [srr_pkg::RANGE_W-1:0]     out_beam_range,
  output logic      [srr_pkg::RETRO_W-1:0]     out_beam_intensity,
  output logic      [srr_pkg::BEAM_W-1:0]      out_beam_number,
  output logic                                 out_index_error,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [srr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [srr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import srr_pkg::*;

  srr_cmd_t cmd;
  srr_sts_t sts;

  assign cfg_ready = 1'b1;

  srr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  srr_datapath #(
    .MAX_RAYS (MAX_RAYS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_ray_index       (in_ray_index),
    .in_ray_range       (in_ray_range),
    .in_ray_retro       (in_ray_retro),
    .in_beam_index      (in_beam_index),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_beam_range     (out_beam_range),
    .out_beam_intensity (out_beam_intensity),
    .out_beam_number    (out_beam_number),
    .out_index_error    (out_index_error)
  );

endmodule
`default_nettype wire

FILE: bench/scan_ray_resampler_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scan_ray_resampler_checker: result prediction and compare for the resampler
// Mirrors the register file and ray store from the observed transactions,
// computes the interpolated beam for every accepted query and checks the
// result channel in order, field by field.
// ----------------------------------------------------------------------------
module scan_ray_resampler_checker #(
  parameter int MAX_RAYS = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  input  wire logic                            in_ready,
  input  wire logic                            in_req_type,
  input  wire logic [srr_pkg::RAYIDX_W-1:0]    in_ray_index,
  input  wire logic [srr_pkg::RANGE_W-1:0]     in_ray_range,
  input  wire logic [srr_pkg::RETRO_W-1:0]     in_ray_retro,
  input  wire logic [srr_pkg::BEAM_W-1:0]      in_beam_index,
  input  wire logic                            out_valid,
  input  wire logic                            out_ready,
  input  wire logic [srr_pkg::RANGE_W-1:0]     out_beam_range,
  input  wire logic [srr_pkg::RETRO_W-1:0]     out_beam_intensity,
  input  wire logic [srr_pkg::BEAM_W-1:0]      out_beam_number,
  input  wire logic                            out_index_error,
  input  wire logic                            cfg_valid,
  input  wire logic                            cfg_ready,
  input  wire logic [srr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [srr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                   fail_count,
  output int                                   pending
);
  import srr_pkg::*;

  typedef struct {
    logic [RANGE_W-1:0] beam_range;
    logic [RETRO_W-1:0] beam_intensity;
    logic [BEAM_W-1:0]  beam_number;
    logic               index_error;
  } beam_result_t;

  logic [RANGE_W-1:0]  range_mem [MAX_RAYS];
  logic [RETRO_W-1:0]  retro_mem [MAX_RAYS];
  logic [RCOUNT_W-1:0] ray_count_q;
  logic [BCOUNT_W-1:0] beam_count_q;
  logic [RANGE_W-1:0]  min_range_q;
  logic [RANGE_W-1:0]  max_range_q;
  logic [RETRO_W-1:0]  min_intensity_q;

  beam_result_t expected_beams [$];

  function automatic beam_result_t resample_beam(logic [BEAM_W-1:0] idx);
    beam_result_t res;
    int unsigned  rays, den, ray_a, ray_b, frac, span, ra, rb, interp, total, inten;
    longint unsigned pos, acc;
    res.beam_number    = idx;
    res.beam_range     = '0;
    res.beam_intensity = '0;
    res.index_error    = 1'b1;
    // raw beam count decides the error, even when it is below two
    if (idx >= beam_count_q) return res;
    rays = (ray_count_q == 0) ? 1 : ((ray_count_q > MAX_RAYS) ? MAX_RAYS : ray_count_q);
    den  = (beam_count_q < 2) ? 1 : beam_count_q - 1;
    pos  = 64'(idx) * 64'(rays - 1);
    ray_a = 32'(pos / den);
    frac  = 32'(((pos % den) << 16) / den);
    if (ray_a > rays - 1) ray_a = rays - 1;
    ray_b = (ray_a + 1 < rays - 1) ? ray_a + 1 : rays - 1;
    span = (max_range_q > min_range_q) ? max_range_q - min_range_q : 0;
    ra = (range_mem[ray_a] < span) ? range_mem[ray_a] : span;
    rb = (range_mem[ray_b] < span) ? range_mem[ray_b] : span;
    acc    = 64'(65536 - frac) * 64'(ra) + 64'(frac) * 64'(rb);
    interp = 32'(acc >> 16);
    total  = interp + min_range_q;
    if (total > max_range_q) total = max_range_q;
    inten = (32'(retro_mem[ray_a]) + 32'(retro_mem[ray_b])) >> 1;
    if (inten < min_intensity_q) inten = min_intensity_q;
    res.beam_range     = total[RANGE_W-1:0];
    res.beam_intensity = inten[RETRO_W-1:0];
    res.index_error    = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin
    beam_result_t want;
    if (!rst_n) begin
      ray_count_q     = RST_RAY_COUNT;
      beam_count_q    = RST_BEAM_COUNT;
      min_range_q     = RST_MIN_RANGE;
      max_range_q     = RST_MAX_RANGE;
      min_intensity_q = RST_MIN_INTENSITY;
      expected_beams.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RAY_COUNT:     ray_count_q     = cfg_data[RCOUNT_W-1:0];
          CFG_BEAM_COUNT:    beam_count_q    = cfg_data[BCOUNT_W-1:0];
          CFG_MIN_RANGE:     min_range_q     = cfg_data[RANGE_W-1:0];
          CFG_MAX_RANGE:     max_range_q     = cfg_data[RANGE_W-1:0];
          CFG_MIN_INTENSITY: min_intensity_q = cfg_data[RETRO_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_req_type == REQ_LOAD) begin
          if (in_ray_index < MAX_RAYS) begin
            range_mem[in_ray_index] = in_ray_range;
            retro_mem[in_ray_index] = in_ray_retro;
          end
        end else begin
          expected_beams.push_back(resample_beam(in_beam_index));
        end
      end
      if (out_valid && out_ready) begin
        if (expected_beams.size() == 0) begin
          $error("result transaction with no query outstanding, beam_number %0d",
                 out_beam_number);
          fail_count++;
        end else begin
          want = expected_beams.pop_front();
          if (out_beam_range !== want.beam_range) begin
            $error("beam_range: expected %0d, actual %0d", want.beam_range, out_beam_range);
            fail_count++;
          end
          if (out_beam_intensity !== want.beam_intensity) begin
            $error("beam_intensity: expected %0d, actual %0d",
                   want.beam_intensity, out_beam_intensity);
            fail_count++;
          end
          if (out_beam_number !== want.beam_number) begin
            $error("beam_number: expected %0d, actual %0d",
                   want.beam_number, out_beam_number);
            fail_count++;
          end
          if (out_index_error !== want.index_error) begin
            $error("index_error: expected %0d, actual %0d",
                   want.index_error, out_index_error);
            fail_count++;
          end
        end
      end
    end
    pending = expected_beams.size();
  end

endmodule

FILE: bench/scan_ray_resampler_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scan_ray_resampler_unit_tb: top-level bench of the scan ray resampler
// Fills the low part of the ray store, runs directed queries over the corner
// settings, then random load/query traffic across several register settings
// with sender gaps and receiver stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module scan_ray_resampler_unit_tb;
  import srr_pkg::*;

  localparam int MAX_RAYS      = 1024;
  localparam int FILL_RAYS     = 256;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_ITEMS   = 38;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_req_type;
  logic [RAYIDX_W-1:0]   in_ray_index;
  logic [RANGE_W-1:0]    in_ray_range;
  logic [RETRO_W-1:0]    in_ray_retro;
  logic [BEAM_W-1:0]     in_beam_index;
  logic                  out_valid;
  logic                  out_ready;
  logic [RANGE_W-1:0]    out_beam_range;
  logic [RETRO_W-1:0]    out_beam_intensity;
  logic [BEAM_W-1:0]     out_beam_number;
  logic                  out_index_error;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;
  int cur_beams;
  int cycle_count;

  scan_ray_resampler_unit #(.MAX_RAYS(MAX_RAYS)) dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_req_type, .in_ray_index, .in_ray_range,
    .in_ray_retro, .in_beam_index,
    .out_valid, .out_ready, .out_beam_range, .out_beam_intensity,
    .out_beam_number, .out_index_error,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  scan_ray_resampler_checker #(.MAX_RAYS(MAX_RAYS)) u_checker (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_req_type, .in_ray_index, .in_ray_range,
    .in_ray_retro, .in_beam_index,
    .out_valid, .out_ready, .out_beam_range, .out_beam_intensity,
    .out_beam_number, .out_index_error,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // mostly random words, with the extremes and short ranges mixed in
  function automatic logic [15:0] rand_word();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 3000));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(logic req, logic [RAYIDX_W-1:0] slot, logic [RANGE_W-1:0] rng_val,
                           logic [RETRO_W-1:0] retro_val, logic [BEAM_W-1:0] beam);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_ray_index  <= slot;
    in_ray_range  <= rng_val;
    in_ray_retro  <= retro_val;
    in_beam_index <= beam;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic query(logic [BEAM_W-1:0] beam);
    send_item(REQ_QUERY, 10'($urandom), rand_word(), rand_word(), beam);
  endtask

  // wait until every result is in, then let a trailing load finish
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic apply_setup(int unsigned rays, int unsigned beams, int unsigned rmin,
                             int unsigned rmax, int unsigned imin);
    drain();
    set_reg(CFG_RAY_COUNT, rays);
    set_reg(CFG_BEAM_COUNT, beams);
    set_reg(CFG_MIN_RANGE, rmin);
    set_reg(CFG_MAX_RANGE, rmax);
    set_reg(CFG_MIN_INTENSITY, imin);
    cfg_valid <= 1'b0;
    cur_beams = beams & 32'h1FFF;
  endtask

  task automatic run_traffic(int count);
    logic [BEAM_W-1:0] beam;
    int lim;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 30) begin
        send_item(REQ_LOAD, 10'($urandom), rand_word(), rand_word(), 12'($urandom));
      end else begin
        lim = (cur_beams > 4096) ? 4096 : cur_beams;
        // most queries land inside the scan, some probe the error path
        if (lim == 0 || $urandom_range(99) < 15) beam = 12'($urandom);
        else beam = 12'($urandom_range(0, lim - 1));
        query(beam);
      end
    end
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = REQ_LOAD;
    in_ray_index   = '0;
    in_ray_range   = '0;
    in_ray_retro   = '0;
    in_beam_index  = '0;
    out_ready      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_RAY_COUNT;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cur_beams      = RST_BEAM_COUNT;
    cycle_count    = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // low slots and the last slot written first; later settings only read
    // within them, large ray counts only with two beams
    for (int i = 0; i < FILL_RAYS; i++)
      send_item(REQ_LOAD, 10'(i), rand_word(), rand_word(), 12'($urandom));
    send_item(REQ_LOAD, 10'(MAX_RAYS - 1), rand_word(), rand_word(), 12'($urandom));

    // directed: extremes under the reset settings
    send_item(REQ_LOAD, 10'd0, 16'hFFFF, 16'hFFFF, 12'hFFF);
    send_item(REQ_LOAD, 10'd1, 16'h0000, 16'h0000, 12'h000);
    send_item(REQ_LOAD, 10'd718, 16'd40000, 16'hFFFF, 12'd5);
    send_item(REQ_LOAD, 10'd719, 16'd1234, 16'd7, 12'd9);
    query(12'd0);
    query(12'd1);
    query(12'd719);
    query(12'd720);
    query(12'hFFF);
    // two rays over three beams: middle beam sits at half weight
    apply_setup(2, 3, 100, 300, 0);
    query(12'd0);
    query(12'd1);
    query(12'd2);
    query(12'd3);
    // max below min collapses the span
    apply_setup(720, 720, 1000, 10, 65535);
    query(12'd1);
    query(12'd718);
    // zero beam count flags every query
    apply_setup(720, 0, 0, 65535, 101);
    query(12'd0);
    query(12'd5);

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0:       apply_setup(FILL_RAYS, 4096, 0, 65535, 0);
        1:       apply_setup(2047, 2, 500, 20000, 65535);
        2:       apply_setup(0, 1, 0, 0, 100);
        3:       apply_setup(1, 2, 1, 65535, 7);
        4:       apply_setup(FILL_RAYS - 1, 8191, 0, 65535, 101);
        5:       apply_setup(1023, 0, 0, 65535, 101);
        6:       apply_setup(1024, 2, 65535, 65535, 0);
        default: apply_setup($urandom_range(1, FILL_RAYS), $urandom_range(2, 4096),
                             $urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 65535));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      run_traffic(PHASE_ITEMS);
    end

    drain();
    if (fail_count == 0 && pending == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

FILE: scan_ray_resampler_unit.f
sv/srr_pkg.sv
sv/srr_ray_store.sv
sv/srr_ctrl.sv
sv/srr_datapath.sv
sv/scan_ray_resampler_unit.sv
bench/scan_ray_resampler_checker.sv
bench/scan_ray_resampler_unit_tb.sv
